FILE: design/mcs_pkg.sv
// Shared types and constants for the matching chain edge step block.
// Holds field widths, operation and transition codes, and the item/result structs.
// No dependencies.
package mcs_pkg;

  localparam int MAX_NODES = 64;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int NODE_W    = 7;
  localparam int CNT_W     = 6;

  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    OP_WRITE_MATE = 2'd0,
    OP_LOAD_STATE = 2'd1,
    OP_EDGE_STEP  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    KIND_REMOVE  = 3'd0,
    KIND_ADD     = 3'd1,
    KIND_SWAP_L  = 3'd2,
    KIND_SWAP_R  = 3'd3,
    KIND_STAY    = 3'd4,
    KIND_LOAD    = 3'd5
  } kind_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [NODE_W-1:0] u;
    logic [NODE_W-1:0] v;
    logic [NODE_W-1:0] partner;
    logic [CNT_W-1:0]  mc;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [NODE_W-1:0] free_left;
    logic [NODE_W-1:0] free_right;
  } chain_state_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [NODE_W-1:0] data;
  } mate_wr_t;

  // Three writes of one step, applied in order w0, w1, w2 (later wins).
  typedef struct packed {
    mate_wr_t w0;
    mate_wr_t w1;
    mate_wr_t w2;
  } mate_wr_set_t;

  typedef struct packed {
    kind_t             kind;
    logic [CNT_W-1:0]  count;
    logic [NODE_W-1:0] free_left;
    logic [NODE_W-1:0] free_right;
    logic [NODE_W-1:0] mate_u;
    logic [NODE_W-1:0] mate_v;
  } result_t;

  // True when a node value addresses an entry of the mate table.
  function automatic logic idx_ok(logic [NODE_W-1:0] x);
    return 32'(x) < 32'(MAX_NODES);
  endfunction

endpackage

FILE: design/matching_chain_edge_step_top.sv
// An accepted item passes the input register, then the result register, and then shows
// on the out_ ports with out_valid high. Throughput: one item per cycle; busy never rises.
// Reset (rst_n low, synchronous) clears the count, free nodes and pipeline valids and sets
// node_count to 64; mate entries keep no reset value. The receiver cannot stall results.
//
// Top level of the matching chain edge step block. Depends on mcs_pkg,
// mcs_mate_table and mcs_step_logic.
module matching_chain_edge_step_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // Command channel.
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_operation,
  input  logic [mcs_pkg::NODE_W-1:0] in_node_u,
  input  logic [mcs_pkg::NODE_W-1:0] in_node_v,
  input  logic [mcs_pkg::NODE_W-1:0] in_partner,
  input  logic [mcs_pkg::CNT_W-1:0]  in_matched_count,
  // Result channel, one beat per command.
  output logic                       out_valid,
  output logic [2:0]                 out_transition_kind,
  output logic [mcs_pkg::CNT_W-1:0]  out_count,
  output logic [mcs_pkg::NODE_W-1:0] out_free_left,
  output logic [mcs_pkg::NODE_W-1:0] out_free_right,
  output logic [mcs_pkg::NODE_W-1:0] out_new_mate_u,
  output logic [mcs_pkg::NODE_W-1:0] out_new_mate_v,
  // Configuration channel: node_count.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mcs_pkg::NODE_W-1:0] cfg_node_count
);
  import mcs_pkg::*;

  // The block takes a command every cycle and a configuration beat at any time.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic              accept;
  logic              item_vld_r;
  item_t             item_r;
  item_t             item_nxt;
  logic [NODE_W-1:0] node_count_r;
  chain_state_t      state_r;
  chain_state_t      state_nxt;
  mate_wr_set_t      wr;
  mate_wr_set_t      wr_gated;
  result_t           result;
  result_t           result_r;
  logic              out_valid_r;
  logic [NODE_W-1:0] rd_u;
  logic [NODE_W-1:0] rd_v;

  assign accept   = start && !busy;
  assign item_nxt = '{op: in_operation, u: in_node_u, v: in_node_v,
                      partner: in_partner, mc: in_matched_count};

  // Stage one: capture the command beat. The table reads for the beat are registered
  // at the same edge inside the table, including the writes of the command ahead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= accept;
    end
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  // Configuration register; the user must write it only while no command is in flight (not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      node_count_r <= cfg_node_count;
    end
  end

  mcs_mate_table u_table (
    .clk       (clk),
    .wr        (wr_gated),
    .rd_en     (accept),
    .rd_addr_a (IDX_W'(in_node_u)),
    .rd_addr_b (IDX_W'(in_node_v)),
    .rd_data_a (rd_u),
    .rd_data_b (rd_v)
  );

  mcs_step_logic u_step (
    .item       (item_r),
    .state      (state_r),
    .node_count (node_count_r),
    .rd_u       (rd_u),
    .rd_v       (rd_v),
    .wr         (wr),
    .state_nxt  (state_nxt),
    .result     (result)
  );

  // Table writes only happen for a live command in stage one.
  always_comb begin
    wr_gated       = wr;
    wr_gated.w0.en = wr.w0.en && item_vld_r;
    wr_gated.w1.en = wr.w1.en && item_vld_r;
    wr_gated.w2.en = wr.w2.en && item_vld_r;
  end

  // Stage two: commit the chain state and register the result beat. The state is
  // updated at the same edge, so a command right behind sees the new matching.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= item_vld_r;
      if (item_vld_r) begin
        state_r <= state_nxt;
      end
    end
    if (item_vld_r) begin
      result_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_transition_kind = result_r.kind;
  assign out_count           = result_r.count;
  assign out_free_left       = result_r.free_left;
  assign out_free_right      = result_r.free_right;
  assign out_new_mate_u      = result_r.mate_u;
  assign out_new_mate_v      = result_r.mate_v;

  // Every accepted command yields its result beat after the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("result beat missing two cycles after a command");

  // A removed edge leaves both of its ends unmatched.
  a_remove_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_transition_kind == KIND_REMOVE) |->
      (out_new_mate_u == node_count_r && out_new_mate_v == node_count_r))
    else $error("remove left an edge end matched");

  // An added edge makes the matching perfect: no free node on either side.
  a_add_perfect: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_transition_kind == KIND_ADD) |->
      (out_free_left == node_count_r && out_free_right == node_count_r))
    else $error("add left a free node");

  // A swap keeps the number of matched pairs.
  a_swap_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_transition_kind == KIND_SWAP_L ||
                   out_transition_kind == KIND_SWAP_R)) |->
      (out_count == $past(state_r.count)))
    else $error("swap changed the pair count");

endmodule

FILE: design/mcs_mate_table.sv
// Mate table register file: one entry per node, up to three ordered writes per cycle.
// Two read ports with registered data that already include the writes of the same edge.
// Depends on mcs_pkg.
module mcs_mate_table (
  input  logic                       clk,
  input  mcs_pkg::mate_wr_set_t      wr,
  input  logic                       rd_en,
  input  logic [mcs_pkg::IDX_W-1:0]  rd_addr_a,
  input  logic [mcs_pkg::IDX_W-1:0]  rd_addr_b,
  output logic [mcs_pkg::NODE_W-1:0] rd_data_a,
  output logic [mcs_pkg::NODE_W-1:0] rd_data_b
);
  import mcs_pkg::*;

  logic [NODE_W-1:0] mate_r [MAX_NODES];
  logic [NODE_W-1:0] rd_a_r;
  logic [NODE_W-1:0] rd_b_r;
  logic              we0;
  logic              we1;
  logic              we2;

  // Value entry a holds once this cycle's writes have landed; later writes win.
  function automatic logic [NODE_W-1:0] read_through(logic [IDX_W-1:0] a);
    logic [NODE_W-1:0] val;
    val = mate_r[a];
    if (wr.w0.en && wr.w0.addr == a) val = wr.w0.data;
    if (wr.w1.en && wr.w1.addr == a) val = wr.w1.data;
    if (wr.w2.en && wr.w2.addr == a) val = wr.w2.data;
    return val;
  endfunction

  // A later write to the same entry masks an earlier one, so each entry takes at most
  // one write per edge.
  assign we2 = wr.w2.en;
  assign we1 = wr.w1.en && !(wr.w2.en && wr.w2.addr == wr.w1.addr);
  assign we0 = wr.w0.en && !(wr.w1.en && wr.w1.addr == wr.w0.addr)
                        && !(wr.w2.en && wr.w2.addr == wr.w0.addr);

  // Entries hold no reset value; an entry is meaningful only once written.
  always_ff @(posedge clk) begin
    if (we0) begin
      mate_r[wr.w0.addr] <= wr.w0.data;
    end
    if (we1) begin
      mate_r[wr.w1.addr] <= wr.w1.data;
    end
    if (we2) begin
      mate_r[wr.w2.addr] <= wr.w2.data;
    end
    if (rd_en) begin
      rd_a_r <= read_through(rd_addr_a);
      rd_b_r <= read_through(rd_addr_b);
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

FILE: design/mcs_step_logic.sv
// Combinational decision logic for one chain step or load operation.
// Produces table writes, the next chain state and the result beat. Depends on mcs_pkg.
module mcs_step_logic (
  input  mcs_pkg::item_t              item,
  input  mcs_pkg::chain_state_t       state,
  input  logic [mcs_pkg::NODE_W-1:0]  node_count,
  input  logic [mcs_pkg::NODE_W-1:0]  rd_u,
  input  logic [mcs_pkg::NODE_W-1:0]  rd_v,
  output mcs_pkg::mate_wr_set_t       wr,
  output mcs_pkg::chain_state_t       state_nxt,
  output mcs_pkg::result_t            result
);
  import mcs_pkg::*;

  logic [NODE_W-1:0] n;
  logic [NODE_W-1:0] mu;
  logic [NODE_W-1:0] mv;
  logic              ends_ok;
  logic [7:0]        two_k;
  logic [7:0]        two_k_p2;
  logic [7:0]        n_ext;
  kind_t             kind;

  // Value of entry x after this cycle's writes, with x = node_u or node_v.
  function automatic logic [NODE_W-1:0] after_read(mate_wr_set_t w, logic [NODE_W-1:0] x,
                                                   logic [NODE_W-1:0] cur);
    logic              ok;
    logic [IDX_W-1:0]  a;
    logic [NODE_W-1:0] val;
    ok  = idx_ok(x);
    a   = IDX_W'(x);
    val = cur;
    if (ok && w.w0.en && w.w0.addr == a) val = w.w0.data;
    if (ok && w.w1.en && w.w1.addr == a) val = w.w1.data;
    if (ok && w.w2.en && w.w2.addr == a) val = w.w2.data;
    return val;
  endfunction

  assign n        = node_count;
  assign mu       = idx_ok(item.u) ? rd_u : n;
  assign mv       = idx_ok(item.v) ? rd_v : n;
  assign ends_ok  = (item.u < n) && (item.v < n) && idx_ok(item.u) && idx_ok(item.v);
  assign two_k    = {1'b0, state.count, 1'b0};
  assign two_k_p2 = two_k + 8'd2;
  assign n_ext    = {1'b0, n};

  always_comb begin
    wr        = '0;
    state_nxt = state;
    kind      = KIND_STAY;
    unique case (item.op)
      OP_WRITE_MATE: begin
        wr.w1 = '{en: idx_ok(item.u), addr: IDX_W'(item.u), data: item.partner};
        kind  = KIND_LOAD;
      end
      OP_LOAD_STATE: begin
        state_nxt = '{count: item.mc, free_left: item.u, free_right: item.v};
        kind      = KIND_LOAD;
      end
      OP_EDGE_STEP: begin
        if (ends_ok) begin
          if (two_k == n_ext && mu == item.v) begin
            wr.w1     = '{en: 1'b1, addr: IDX_W'(item.u), data: n};
            wr.w2     = '{en: 1'b1, addr: IDX_W'(item.v), data: n};
            state_nxt = '{count: state.count - CNT_W'(1), free_left: item.u,
                          free_right: item.v};
            kind      = KIND_REMOVE;
          end else if (two_k_p2 == n_ext) begin
            if (mu == n && mv == n) begin
              wr.w1     = '{en: 1'b1, addr: IDX_W'(item.u), data: item.v};
              wr.w2     = '{en: 1'b1, addr: IDX_W'(item.v), data: item.u};
              state_nxt = '{count: state.count + CNT_W'(1), free_left: n, free_right: n};
              kind      = KIND_ADD;
            end else if (mu != n && mv == n) begin
              wr.w0                = '{en: idx_ok(mu), addr: IDX_W'(mu), data: n};
              wr.w1                = '{en: 1'b1, addr: IDX_W'(item.u), data: item.v};
              wr.w2                = '{en: 1'b1, addr: IDX_W'(item.v), data: item.u};
              state_nxt.free_right = mu;
              kind                 = KIND_SWAP_L;
            end else if (mu == n && mv != n) begin
              wr.w0               = '{en: idx_ok(mv), addr: IDX_W'(mv), data: n};
              wr.w1               = '{en: 1'b1, addr: IDX_W'(item.u), data: item.v};
              wr.w2               = '{en: 1'b1, addr: IDX_W'(item.v), data: item.u};
              state_nxt.free_left = mv;
              kind                = KIND_SWAP_R;
            end
          end
        end
      end
      default: begin
        kind = KIND_STAY;
      end
    endcase
  end

  always_comb begin
    result.kind       = kind;
    result.count      = state_nxt.count;
    result.free_left  = state_nxt.free_left;
    result.free_right = state_nxt.free_right;
    result.mate_u     = after_read(wr, item.u, mu);
    result.mate_v     = after_read(wr, item.v, mv);
  end

endmodule
